### hw/rtl/ess_pkg.sv
// shared types and constants of the seeded moving-average filter
// no dependencies: imported by ess_div, ema_sma_seeded_filter and tb_top
package ess_pkg;

   // word widths
   localparam int SAMPLE_W = 32;
   localparam int CNT_W    = 16;
   localparam int SUM_W    = SAMPLE_W + CNT_W;
   localparam int DELTA_W  = SAMPLE_W + 1;
   localparam int NUM_W    = SUM_W;
   localparam int DEN_W    = CNT_W + 1;
   localparam int QUO_W    = NUM_W + 1;
   localparam int ACC_W    = QUO_W + 1;

   // divider sequencing: one quotient bit per step
   localparam int DIV_STEPS = NUM_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // configuration port
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = CNT_W;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_LENGTH = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_WILDER_MODE   = CSR_IDX_W'(1);
   localparam logic [CNT_W-1:0]     WINDOW_RESET      = CNT_W'(14);

   // saturation bounds of the sample range, at accumulator width
   localparam logic signed [ACC_W-1:0] ACC_SMAX =
      {{(ACC_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_SMIN =
      {{(ACC_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};

   // request to the shared divider
   typedef struct packed {
      logic                    start;
      logic signed [NUM_W-1:0] num;
      logic [DEN_W-1:0]        den;
   } div_req_type;

   // answer from the shared divider
   typedef struct packed {
      logic                    done;
      logic signed [QUO_W-1:0] quo;
   } div_rsp_type;

endpackage

### hw/rtl/ess_div.sv
// iterative signed divider, rounded to nearest with ties away from zero
// depends on ess_pkg for widths and the request and answer structs
module ess_div import ess_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam logic [1:0] DV_IDLE  = 2'd0;
   localparam logic [1:0] DV_RUN   = 2'd1;
   localparam logic [1:0] DV_ROUND = 2'd2;

   logic [1:0]              state_ff, state_in;
   logic [DEN_W-1:0]        rem_ff, rem_in;
   logic [NUM_W-1:0]        quo_ff, quo_in;
   logic [DEN_W-1:0]        den_ff, den_in;
   logic                    neg_ff, neg_in;
   logic [DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic                    done_ff, done_in;
   logic signed [QUO_W-1:0] res_ff, res_in;

   logic [NUM_W-1:0]        num_u;
   logic [DEN_W:0]          shifted;
   logic [DEN_W:0]          trial;
   logic                    fits;
   logic                    round_up;
   logic [QUO_W-1:0]        q_round;

   // one restoring step per cycle
   always_comb begin
      num_u    = div_req.num;
      shifted  = {rem_ff, quo_ff[NUM_W-1]};
      trial    = shifted - {1'b0, den_ff};
      fits     = shifted >= {1'b0, den_ff};
      round_up = {rem_ff, 1'b0} >= {1'b0, den_ff};
      q_round  = {1'b0, quo_ff} + QUO_W'(round_up);

      state_in = state_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      res_in   = res_ff;

      case (state_ff)
         DV_IDLE: begin
            if (div_req.start) begin
               neg_in   = num_u[NUM_W-1];
               quo_in   = num_u[NUM_W-1] ? (~num_u + NUM_W'(1)) : num_u;
               rem_in   = '0;
               den_in   = div_req.den;
               cnt_in   = '0;
               state_in = DV_RUN;
            end
         end
         DV_RUN: begin
            rem_in = fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], fits};
            cnt_in = cnt_ff + DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = DV_ROUND;
            end
         end
         DV_ROUND: begin
            res_in   = neg_ff ? -$signed(q_round) : $signed(q_round);
            done_in  = 1'b1;
            state_in = DV_IDLE;
         end
         default: begin
            state_in = DV_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      res_ff <= res_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = res_ff;

endmodule

### hw/rtl/ema_sma_seeded_filter.sv
// top level of the seeded exponential moving-average filter
// depends on ess_pkg and the shared divider ess_div
//
// Usage:
//  - req channel: req_sample (signed Q16.16) and req_series_start; a word is
//    taken when req_valid is high and req_stall low. req_stall stays high
//    while a word is being worked on.
//  - rsp channel: one word per sample, rsp_average and rsp_average_valid;
//    rsp_average reads zero while the series is still seeding.
//  - csr channel: index 0 window length n, index 1 wilder mode; csr_ready is
//    always high. Write only while the block is idle.
//  - A sample that only adds to the seed sum goes from set-up straight to
//    the output step, bypassing the divider; a new sample may follow once
//    the block is idle again.
//  - A sample that forms the seed mean or updates the average goes through
//    the shared divider, one quotient bit a cycle over 48 bits and then a
//    rounding step; the next sample is taken only after its result is written.
//  - The result sits in an output register; a stalled receiver holds it, and
//    the block still takes and works the next sample, waiting only to write
//    its result until the previous one has gone.
//  - Synchronous reset: registers return to n = 14, standard alpha, and an
//    empty series; no output word is pending.
module ema_sma_seeded_filter import ess_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   // input channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_series_start,
   // result channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_average,
   output logic                       rsp_average_valid,
   // configuration channel
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PREP = 3'd1;
   localparam logic [2:0] ST_LOAD = 3'd2;
   localparam logic [2:0] ST_WAIT = 3'd3;
   localparam logic [2:0] ST_POST = 3'd4;

   logic [2:0]                 state_ff, state_in;
   logic [CNT_W-1:0]           window_ff, window_in;
   logic                       wilder_ff, wilder_in;
   logic [CNT_W-1:0]           seen_ff, seen_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic signed [SAMPLE_W-1:0] avg_ff, avg_in;
   logic                       seeded_ff, seeded_in;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic                       start_ff, start_in;
   logic signed [NUM_W-1:0]    num_ff, num_in;
   logic [DEN_W-1:0]           den_ff, den_in;
   logic                       has_div_ff, has_div_in;
   logic                       seed_path_ff, seed_path_in;
   logic signed [QUO_W-1:0]    quo_ff, quo_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_avg_ff, rsp_avg_in;
   logic                       rsp_avg_valid_ff, rsp_avg_valid_in;

   logic [CNT_W-1:0]           n_eff;
   logic signed [SUM_W-1:0]    sum_base;
   logic [CNT_W-1:0]           seen_base;
   logic signed [SAMPLE_W-1:0] avg_base;
   logic                       seeded_base;
   logic signed [SUM_W-1:0]    sum_next;
   logic [CNT_W-1:0]           seen_next;
   logic signed [DELTA_W-1:0]  delta;
   logic signed [NUM_W-1:0]    delta_ext;
   logic signed [ACC_W-1:0]    acc;
   logic signed [SAMPLE_W-1:0] acc_sat;
   logic                       out_free;

   div_req_type div_req;
   div_rsp_type div_rsp;

   // shared divider
   ess_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign div_req.start = (state_ff == ST_LOAD);
   assign div_req.num   = num_ff;
   assign div_req.den   = den_ff;

   // handshake outputs
   assign req_stall         = (state_ff != ST_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_average       = rsp_avg_ff;
   assign rsp_average_valid = rsp_avg_valid_ff;

   // datapath helpers
   always_comb begin
      n_eff       = (window_ff == '0) ? CNT_W'(1) : window_ff;
      sum_base    = start_ff ? '0 : sum_ff;
      seen_base   = start_ff ? '0 : seen_ff;
      avg_base    = start_ff ? '0 : avg_ff;
      seeded_base = start_ff ? 1'b0 : seeded_ff;
      sum_next    = sum_base + SUM_W'(sample_ff);
      seen_next   = seen_base + CNT_W'(1);
      delta       = DELTA_W'(sample_ff) - DELTA_W'(avg_base);
      delta_ext   = NUM_W'(delta);
      acc         = (seed_path_ff ? '0 : ACC_W'(avg_ff)) + ACC_W'(quo_ff);
      if (acc > ACC_SMAX) begin
         acc_sat = ACC_SMAX[SAMPLE_W-1:0];
      end else if (acc < ACC_SMIN) begin
         acc_sat = ACC_SMIN[SAMPLE_W-1:0];
      end else begin
         acc_sat = acc[SAMPLE_W-1:0];
      end
      out_free = !rsp_valid_ff || !rsp_stall;
   end

   // sequencer and next-state logic
   always_comb begin
      state_in         = state_ff;
      window_in        = window_ff;
      wilder_in        = wilder_ff;
      seen_in          = seen_ff;
      sum_in           = sum_ff;
      avg_in           = avg_ff;
      seeded_in        = seeded_ff;
      sample_in        = sample_ff;
      start_in         = start_ff;
      num_in           = num_ff;
      den_in           = den_ff;
      has_div_in       = has_div_ff;
      seed_path_in     = seed_path_ff;
      quo_in           = quo_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_avg_in       = rsp_avg_ff;
      rsp_avg_valid_in = rsp_avg_valid_ff;

      // register writes
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_WINDOW_LENGTH: window_in = csr_wdata;
            REG_WILDER_MODE:   wilder_in = csr_wdata[0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sample_in = req_sample;
               start_in  = req_series_start;
               state_in  = ST_PREP;
            end
         end
         // clear on series start, then seed or set up the update division
         ST_PREP: begin
            avg_in    = avg_base;
            seeded_in = seeded_base;
            sum_in    = sum_base;
            seen_in   = seen_base;
            if (!seeded_base) begin
               sum_in       = sum_next;
               seen_in      = seen_next;
               num_in       = sum_next;
               den_in       = {1'b0, seen_next};
               seed_path_in = 1'b1;
               has_div_in   = (seen_next >= n_eff);
               state_in     = (seen_next >= n_eff) ? ST_LOAD : ST_POST;
            end else begin
               num_in       = wilder_ff ? delta_ext : {delta_ext[NUM_W-2:0], 1'b0};
               den_in       = wilder_ff ? {1'b0, n_eff} : ({1'b0, n_eff} + DEN_W'(1));
               seed_path_in = 1'b0;
               has_div_in   = 1'b1;
               state_in     = ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_rsp.done) begin
               quo_in   = div_rsp.quo;
               state_in = ST_POST;
            end
         end
         // after a division add and saturate; hand over the result word
         ST_POST: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (has_div_ff) begin
                  avg_in           = acc_sat;
                  seeded_in        = 1'b1;
                  rsp_avg_in       = acc_sat;
                  rsp_avg_valid_in = 1'b1;
               end else begin
                  rsp_avg_in       = '0;
                  rsp_avg_valid_in = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         window_ff    <= WINDOW_RESET;
         wilder_ff    <= 1'b0;
         seen_ff      <= '0;
         sum_ff       <= '0;
         avg_ff       <= '0;
         seeded_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         wilder_ff    <= wilder_in;
         seen_ff      <= seen_in;
         sum_ff       <= sum_in;
         avg_ff       <= avg_in;
         seeded_ff    <= seeded_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      sample_ff        <= sample_in;
      start_ff         <= start_in;
      num_ff           <= num_in;
      den_ff           <= den_in;
      has_div_ff       <= has_div_in;
      seed_path_ff     <= seed_path_in;
      quo_ff           <= quo_in;
      rsp_avg_ff       <= rsp_avg_in;
      rsp_avg_valid_ff <= rsp_avg_valid_in;
   end

   // an accepted word always moves the sequencer into set-up
   a_accept_prep: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == ST_PREP)
      else $error("accepted word did not start set-up");

   // the divider only answers while the sequencer waits for it
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == ST_WAIT)
      else $error("divider answer outside the wait state");

   // no average is kept before the seed mean exists
   a_avg_unseeded: assert property (@(posedge clock) disable iff (reset)
      !seeded_ff |-> avg_ff == '0)
      else $error("average held while unseeded");

   // an invalid result word carries a zero average
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_avg_valid_ff |-> rsp_avg_ff == '0)
      else $error("non-zero average on an invalid result");

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// self-checking testbench of the seeded exponential moving-average filter
// depends on ess_pkg and the filter rtl; predicts every result word internally
module tb_top;
   import ess_pkg::*;

   // drain allowance after the last answer; the slowest word needs the divider
   localparam int DRAIN_CYCLES  = 64;
   localparam int WATCHDOG_MAX  = 4000;
   localparam int HOLD_CYCLES   = 400;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = CSR_IDX_W'(15);
   localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   typedef struct {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       series_start;
      int unsigned                gap;
   } sample_word_type;

   typedef struct {
      logic signed [SAMPLE_W-1:0] average;
      logic                       valid;
   } avg_word_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic                       req_series_start = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_average;
   logic                       rsp_average_valid;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_wdata = '0;

   // stimulus and expectation stores
   sample_word_type sample_pending[$];
   avg_word_type    avg_expected[$];
   int unsigned  words_queued = 0;
   int unsigned  words_taken  = 0;
   int unsigned  fail_cnt     = 0;

   // predictor copy of configuration and series state
   logic [CNT_W-1:0] win_len;
   logic             wilder_sel;
   logic [CNT_W-1:0] seen_cnt;
   longint           seed_acc;
   longint           ema_avg;
   bit               seeded;

   // driver and monitor bookkeeping
   int          drv_wait;
   int unsigned stall_left;
   int unsigned hold_left;
   int unsigned rsp_gap_max;
   int unsigned rsp_cnt;
   int unsigned quiet_cycles;

   ema_sma_seeded_filter dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample        (req_sample),
      .req_series_start  (req_series_start),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_average       (rsp_average),
      .rsp_average_valid (rsp_average_valid),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #5 clock = ~clock;

   // quotient rounded to nearest, ties away from zero; den is positive
   function automatic longint round_quot(longint num, longint den);
      longint mag;
      longint q;
      longint r;
      mag = (num < 0) ? -num : num;
      q   = mag / den;
      r   = mag % den;
      if (r >= den - r) q++;
      return (num < 0) ? -q : q;
   endfunction

   function automatic longint sat_sample(longint v);
      if (v > longint'(S_MAX)) return longint'(S_MAX);
      if (v < longint'(S_MIN)) return longint'(S_MIN);
      return v;
   endfunction

   // advance the series state by one sample and queue the expected word
   function automatic void ema_predict(logic signed [SAMPLE_W-1:0] x, logic start);
      longint       n;
      longint       delta;
      longint       step;
      avg_word_type w;
      n = (win_len == 0) ? 1 : longint'(win_len);
      if (start) begin
         seen_cnt = '0;
         seed_acc = 0;
         ema_avg  = 0;
         seeded   = 1'b0;
      end
      if (!seeded) begin
         seed_acc += longint'(x);
         seen_cnt++;
         if (longint'(seen_cnt) >= n) begin
            ema_avg = sat_sample(round_quot(seed_acc, longint'(seen_cnt)));
            seeded  = 1'b1;
         end
      end else begin
         delta = longint'(x) - ema_avg;
         if (wilder_sel) step = round_quot(delta, n);
         else step = round_quot(2 * delta, n + 1);
         ema_avg = sat_sample(ema_avg + step);
      end
      w.average = seeded ? SAMPLE_W'(ema_avg) : '0;
      w.valid   = seeded;
      avg_expected.push_back(w);
   endfunction

   // sample near the series level, with the odd extreme or wild value
   function automatic logic signed [SAMPLE_W-1:0] draw_sample(longint level);
      longint noise;
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: begin
            case ($urandom_range(0, 4))
               0: return S_MAX;
               1: return S_MIN;
               2: return '0;
               3: return -1;
               default: return 1;
            endcase
         end
         default: begin
            noise = longint'($signed($urandom)) >>> $urandom_range(8, 31);
            return SAMPLE_W'(sat_sample(level + noise));
         end
      endcase
   endfunction

   // input driver: a gap before each word, payload held while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         drv_wait   = -1;
         win_len    = WINDOW_RESET;
         wilder_sel = 1'b0;
         seen_cnt   = '0;
         seed_acc   = 0;
         ema_avg    = 0;
         seeded     = 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            ema_predict(req_sample, req_series_start);
            words_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (drv_wait < 0 && sample_pending.size() > 0) drv_wait = sample_pending[0].gap;
            if (drv_wait == 0) begin
               req_sample       <= sample_pending[0].sample;
               req_series_start <= sample_pending[0].series_start;
               req_valid        <= 1'b1;
               void'(sample_pending.pop_front());
               drv_wait = -1;
            end else begin
               req_valid <= 1'b0;
               if (drv_wait > 0) drv_wait--;
            end
         end
      end
   end

   // result monitor: random stall per word, long hold-offs now and then
   always @(posedge clock) begin
      avg_word_type w;
      if (reset) begin
         rsp_stall   <= 1'b0;
         stall_left  = 0;
         hold_left   = 0;
         rsp_gap_max = 0;
         rsp_cnt     = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (avg_expected.size() == 0) begin
               $error("unexpected result word: average %0d valid %0b",
                      rsp_average, rsp_average_valid);
               fail_cnt++;
            end else begin
               w = avg_expected.pop_front();
               if (rsp_average !== w.average) begin
                  $error("average: expected %0d, actual %0d", w.average, rsp_average);
                  fail_cnt++;
               end
               if (rsp_average_valid !== w.valid) begin
                  $error("average_valid: expected %0b, actual %0b",
                         w.valid, rsp_average_valid);
                  fail_cnt++;
               end
            end
            rsp_cnt++;
            if (rsp_cnt % 50 == 0) rsp_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 16;
            stall_left = $urandom_range(0, rsp_gap_max);
            if (rsp_cnt == 300 || rsp_cnt == 1200) hold_left = HOLD_CYCLES;
         end else if (hold_left > 0) begin
            hold_left--;
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_stall <= (hold_left > 0) || (stall_left > 0);
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
                   (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   task automatic push_word(logic signed [SAMPLE_W-1:0] s, logic start);
      sample_word_type w;
      w.sample       = s;
      w.series_start = start;
      w.gap          = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      sample_pending.push_back(w);
      words_queued++;
   endtask

   // wait until every word is taken and answered, then let the divider settle
   task automatic wait_drained();
      do @(posedge clock);
      while (words_taken != words_queued || avg_expected.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock);
      while (!csr_ready);
      case (idx)
         REG_WINDOW_LENGTH: win_len = data;
         REG_WILDER_MODE:   wilder_sel = data[0];
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   // random series: mostly whole seeded series, some cut short or restarted
   task automatic random_series(int unsigned count, int unsigned n);
      int unsigned left;
      int unsigned len;
      int unsigned k;
      longint      level;
      left = count;
      while (left > 0) begin
         if ($urandom_range(0, 6) != 0) len = n + $urandom_range(0, 2 * n + 8);
         else len = $urandom_range(1, n);
         if (len > left) len = left;
         level = longint'($signed($urandom)) >>> $urandom_range(0, 20);
         for (k = 0; k < len; k++)
            push_word(draw_sample(level), (k == 0) || ($urandom_range(0, 99) == 0));
         left -= len;
      end
   endtask

   initial begin
      int unsigned ph_n[10]   = '{1, 1, 2, 3, 14, 14, 0, 5, 40, 255};
      bit          ph_w[10]   = '{0, 1, 1, 0, 0, 1, 1, 0, 1, 0};
      int unsigned ph_cnt[10] = '{100, 80, 120, 120, 250, 150, 60, 150, 150, 350};
      int unsigned p;
      int unsigned k;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset settings, no series start mark: seeding at the positive extreme
      repeat (14) push_word(S_MAX, 1'b0);
      push_word(S_MIN, 1'b0);
      wait_drained();

      // zero window behaves as one, alpha of one
      write_reg(REG_WINDOW_LENGTH, '0);
      write_reg(REG_WILDER_MODE, CSR_DATA_W'(1));
      push_word(S_MIN, 1'b1);
      push_word(S_MAX, 1'b0);
      wait_drained();

      // rounding ties away from zero on the seed, then an update
      write_reg(REG_WINDOW_LENGTH, CSR_DATA_W'(2));
      write_reg(REG_WILDER_MODE, '0);
      push_word(-1, 1'b1);
      push_word(-2, 1'b0);
      push_word(3, 1'b0);
      wait_drained();

      // window shortened while seeding: the seed is the mean of all summed
      write_reg(REG_WINDOW_LENGTH, CSR_DATA_W'(10));
      push_word(5, 1'b1);
      push_word(6, 1'b0);
      push_word(7, 1'b0);
      push_word(9, 1'b0);
      wait_drained();
      write_reg(REG_WINDOW_LENGTH, CSR_DATA_W'(2));
      push_word(-8, 1'b0);
      wait_drained();

      // widest window and mode change after seeding
      write_reg(REG_WINDOW_LENGTH, '1);
      write_reg(REG_WILDER_MODE, CSR_DATA_W'(1));
      push_word(S_MAX, 1'b0);
      push_word(S_MIN, 1'b0);
      wait_drained();
      write_reg(REG_SPARE, '1);

      // random phases over a spread of windows and both modes
      for (p = 0; p < 10; p++) begin
         write_reg(REG_WINDOW_LENGTH, CSR_DATA_W'(ph_n[p]));
         write_reg(REG_WILDER_MODE, CSR_DATA_W'(ph_w[p]));
         random_series(ph_cnt[p], (ph_n[p] == 0) ? 1 : ph_n[p]);
         wait_drained();
      end

      // seed on a short window, then run on with the widest one
      write_reg(REG_WINDOW_LENGTH, CSR_DATA_W'(4));
      push_word($urandom, 1'b1);
      repeat (3) push_word($urandom, 1'b0);
      wait_drained();
      write_reg(REG_WINDOW_LENGTH, '1);
      write_reg(REG_WILDER_MODE, CSR_DATA_W'($urandom_range(0, 1)));
      for (k = 0; k < 96; k++) push_word(draw_sample(0), 1'b0);
      wait_drained();

      if (fail_cnt == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
